// ===== design/afl_pkg.sv =====
// afl_pkg: shared constants, register codes and saturation helper for the flanger core
// no dependencies; imported by audio_flanger_delay_line_core, afl_checker and the testbench
`timescale 1ns / 1ps

package afl_pkg;

  localparam int CHANNELS    = 8;
  localparam int MAX_DELAY   = 2048;
  localparam int SWEEP_DEPTH = 65536;
  localparam int SAMPLE_BITS = 24;

  // port field widths
  localparam int CHAN_W = 3;
  localparam int TI_W   = 16;
  localparam int TV_W   = 27;
  localparam int CFG_W  = 17;
  localparam int CFGI_W = 3;

  // register widths
  localparam int DLEN_W = 12;
  localparam int SLEN_W = 17;
  localparam int PH_W   = 17;
  localparam int WET_W  = 16;
  localparam int DRY_W  = 17;

  // storage geometry
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int DA_W     = $clog2(MAX_DELAY);
  localparam int SA_W     = $clog2(SWEEP_DEPTH);
  localparam int DL_AW    = CH_W + DA_W;
  localparam int DL_DEPTH = 1 << DL_AW;
  localparam int FRAC_W   = 16;

  localparam int SAT_W = 48;

  typedef enum logic [CFGI_W-1:0] {
    REG_DELAY_LENGTH   = 3'd0,
    REG_SWEEP_LENGTH   = 3'd1,
    REG_CHANNEL_PHASE  = 3'd2,
    REG_FEEDBACK_GAIN  = 3'd3,
    REG_WET_GAIN       = 3'd4,
    REG_DRY_GAIN       = 3'd5,
    REG_QUADRATIC_MODE = 3'd6
  } cfg_reg_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = {{(SAT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== design/audio_flanger_delay_line_core.sv =====
// throughput: one item at a time, set by the bit-per-cycle multiplier (17 steps per
// product) and the bit-per-cycle remainder unit used for the write, table index, tap
// and sweep positions; a table load is taken in idle
// reset: synchronous, active low; afterwards a clearing pass zeroes all 16384 words of the
// delay memory while input is held off, configuration writes are taken throughout
`timescale 1ns / 1ps

module audio_flanger_delay_line_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_cmd,
  input  logic [afl_pkg::CHAN_W-1:0]             in_channel,
  input  logic signed [afl_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic                                   in_first_of_frame,
  input  logic                                   in_last_of_frame,
  input  logic [afl_pkg::TI_W-1:0]               in_table_index,
  input  logic [afl_pkg::TV_W-1:0]               in_table_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [afl_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic [afl_pkg::CHAN_W-1:0]             out_channel,
  input  logic                                   cfg_we,
  input  logic [afl_pkg::CFGI_W-1:0]             cfg_index,
  input  logic [afl_pkg::CFG_W-1:0]              cfg_wdata
);
  import afl_pkg::*;

  localparam int ACC_W = 62;
  localparam int MC_W  = 45;
  localparam int MB_W  = 17;
  localparam int MOD_W = 20;
  localparam int REM_W = 17;
  localparam int CNT_W = 5;
  localparam int OFS_W = 19;
  localparam int WP_N  = DA_W;
  localparam int IDX_N = MOD_W;
  localparam int TAP_N = DA_W + 2;
  localparam int SP_N  = SA_W + 1;
  localparam int D_W   = 28;

  typedef enum logic [25:0] {
    S_CLEAR     = 26'h0000001,
    S_IDLE      = 26'h0000002,
    S_WP_MOD    = 26'h0000004,
    S_WP_SET    = 26'h0000008,
    S_OFS_MUL   = 26'h0000010,
    S_OFS_SET   = 26'h0000020,
    S_IDX_MOD   = 26'h0000040,
    S_TBL_RD    = 26'h0000080,
    S_FB_MUL    = 26'h0000100,
    S_FB_WR     = 26'h0000200,
    S_TAP_START = 26'h0000400,
    S_TAP_MOD   = 26'h0000800,
    S_TAP_RD    = 26'h0001000,
    S_TAP_WAIT  = 26'h0002000,
    S_INTERP    = 26'h0004000,
    S_QA_MUL    = 26'h0008000,
    S_QA_SUM    = 26'h0010000,
    S_QT_MUL    = 26'h0020000,
    S_DEL_SET   = 26'h0040000,
    S_MIX1_MUL  = 26'h0080000,
    S_MIX1_SET  = 26'h0100000,
    S_MIX2_MUL  = 26'h0200000,
    S_MIX2_SET  = 26'h0400000,
    S_SP_MOD    = 26'h0800000,
    S_SP_SET    = 26'h1000000,
    S_OUT       = 26'h2000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [DLEN_W-1:0]       dly_len_r;
  logic [SLEN_W-1:0]       swp_len_r;
  logic [PH_W-1:0]         phase_r;
  logic signed [CFG_W-1:0] fbg_r;
  logic [WET_W-1:0]        wet_r;
  logic [DRY_W-1:0]        dry_r;
  logic                    quad_r;
  logic [DLEN_W-1:0]       dly_cfg;
  logic [SLEN_W-1:0]       swp_cfg;
  logic [PH_W-1:0]         ph_cfg;

  // architectural state
  logic [DA_W-1:0]               wp_r;
  logic [SA_W-1:0]               sp_r;
  logic signed [SAMPLE_BITS-1:0] last_q_r [CHANNELS];
  logic [DL_AW-1:0]              clr_cnt_r;
  logic signed [SAMPLE_BITS-1:0] dl_mem [DL_DEPTH];
  logic signed [SAMPLE_BITS-1:0] dl_q_r;
  logic [TV_W-1:0]               tbl_mem [SWEEP_DEPTH];
  logic [TV_W-1:0]               tbl_q_r;

  // item registers
  logic [CHAN_W-1:0]             ch_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          first_r;
  logic                          last_r;
  logic [DA_W-1:0]               pos_r;
  logic [1:0]                    tap_k_r;
  logic signed [SAMPLE_BITS-1:0] d_r [3];
  logic signed [SAMPLE_BITS-1:0] del_r;
  logic signed [ACC_W-1:0]       p1_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CHAN_W-1:0]             out_channel_r;

  // shared serial units
  logic signed [ACC_W-1:0] acc_r, acc_nxt, mul_add;
  logic signed [MC_W-1:0]  mc_r;
  logic [MB_W-1:0]         mb_r;
  logic                    msgn_r;
  logic [MOD_W-1:0]        num_r;
  logic [REM_W-1:0]        rem_r, rem_nxt, div_r;
  logic [REM_W:0]          mod_t;
  logic [CNT_W-1:0]        cnt_r;
  logic                    last_step;

  // datapath helpers
  logic [19:0]                   ch_sl;
  logic signed [ACC_W-1:0]       rnd16, rnd33, mix_sh;
  logic [IDX_N-1:0]              idx_num;
  logic [TAP_N-1:0]              tap_num;
  logic [DA_W-1:0]               wp_rem, pos_val;
  logic signed [SAMPLE_BITS-1:0] wr_val, del_val, mix_val;
  logic signed [D_W-1:0]         e1, e2, a2, b2;
  logic signed [MC_W-1:0]        qsum;
  logic [FRAC_W-1:0]             frac;
  logic [DA_W-1:0]               ip;
  logic [1:0]                    tap_last;
  logic                          out_free;
  logic                          sample_acc;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_channel    = out_channel_r;
  assign out_free       = !out_valid_r || out_ready;
  assign sample_acc     = in_valid && in_ready && !in_cmd;
  assign last_step      = (cnt_r == CNT_W'(1));

  // clamping of written configuration values
  always_comb begin
    dly_cfg = cfg_wdata[DLEN_W-1:0];
    if (dly_cfg < DLEN_W'(3)) dly_cfg = DLEN_W'(3);
    if (dly_cfg > DLEN_W'(MAX_DELAY)) dly_cfg = DLEN_W'(MAX_DELAY);
    swp_cfg = cfg_wdata[SLEN_W-1:0];
    if (swp_cfg < SLEN_W'(1)) swp_cfg = SLEN_W'(1);
    if (swp_cfg > SLEN_W'(SWEEP_DEPTH)) swp_cfg = SLEN_W'(SWEEP_DEPTH);
    ph_cfg = cfg_wdata[PH_W-1:0];
    if (ph_cfg > PH_W'(65536)) ph_cfg = PH_W'(65536);
  end

  // multiplier: msb-first shift-add, top bit negative for a signed multiplier
  always_comb begin
    mul_add = '0;
    if (mb_r[MB_W-1]) begin
      mul_add = (msgn_r && cnt_r == CNT_W'(MB_W)) ? -ACC_W'(mc_r) : ACC_W'(mc_r);
    end
    acc_nxt = (acc_r <<< 1) + mul_add;
  end

  // remainder unit: restoring step, one numerator bit per cycle
  always_comb begin
    mod_t = {rem_r, num_r[MOD_W-1]};
    if (mod_t >= {1'b0, div_r}) begin
      rem_nxt = REM_W'(mod_t - {1'b0, div_r});
    end else begin
      rem_nxt = mod_t[REM_W-1:0];
    end
  end

  always_comb begin
    ch_sl   = 20'(ch_r) * 20'(swp_len_r);
    rnd16   = (acc_r + ACC_W'(32768)) >>> 16;
    rnd33   = (acc_r + ACC_W'(64'sd1 <<< 32)) >>> 33;
    mix_sh  = (p1_r + acc_r + ACC_W'(32768)) >>> 16;
    idx_num = IDX_N'(sp_r) + IDX_N'(rnd16[OFS_W-1:0]);
    ip      = tbl_q_r[FRAC_W +: DA_W];
    frac    = tbl_q_r[FRAC_W-1:0];
    tap_num = TAP_N'(pos_r) + TAP_N'(ip) + TAP_N'(tap_k_r);
    wp_rem  = rem_r[DA_W-1:0];
    if (!first_r) begin
      pos_val = wp_rem;
    end else if (wp_rem == '0) begin
      pos_val = DA_W'(dly_len_r - DLEN_W'(1));
    end else begin
      pos_val = wp_rem - DA_W'(1);
    end
    wr_val  = sat_sample(SAT_W'(x_r) + SAT_W'(rnd16));
    del_val = sat_sample(SAT_W'(d_r[0]) + SAT_W'(rnd33));
    mix_val = sat_sample(SAT_W'(mix_sh));
    e1      = D_W'(d_r[1]) - D_W'(d_r[0]);
    e2      = D_W'(d_r[2]) - D_W'(d_r[0]);
    a2      = e2 - (e1 <<< 1);
    b2      = (e1 <<< 2) - e2;
    qsum    = MC_W'(acc_r) + (MC_W'(b2) <<< 16);
    tap_last = quad_r ? 2'd2 : 2'd1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:     if (clr_cnt_r == '1) state_nxt = S_IDLE;
      S_IDLE:      if (sample_acc) state_nxt = S_WP_MOD;
      S_WP_MOD:    if (last_step) state_nxt = S_WP_SET;
      S_WP_SET:    state_nxt = S_OFS_MUL;
      S_OFS_MUL:   if (last_step) state_nxt = S_OFS_SET;
      S_OFS_SET:   state_nxt = S_IDX_MOD;
      S_IDX_MOD:   if (last_step) state_nxt = S_TBL_RD;
      S_TBL_RD:    state_nxt = S_FB_MUL;
      S_FB_MUL:    if (last_step) state_nxt = S_FB_WR;
      S_FB_WR:     state_nxt = S_TAP_START;
      S_TAP_START: state_nxt = S_TAP_MOD;
      S_TAP_MOD:   if (last_step) state_nxt = S_TAP_RD;
      S_TAP_RD:    state_nxt = S_TAP_WAIT;
      S_TAP_WAIT:  state_nxt = (tap_k_r == tap_last) ? S_INTERP : S_TAP_START;
      S_INTERP:    state_nxt = quad_r ? S_QA_MUL : S_QT_MUL;
      S_QA_MUL:    if (last_step) state_nxt = S_QA_SUM;
      S_QA_SUM:    state_nxt = S_QT_MUL;
      S_QT_MUL:    if (last_step) state_nxt = S_DEL_SET;
      S_DEL_SET:   state_nxt = S_MIX1_MUL;
      S_MIX1_MUL:  if (last_step) state_nxt = S_MIX1_SET;
      S_MIX1_SET:  state_nxt = S_MIX2_MUL;
      S_MIX2_MUL:  if (last_step) state_nxt = S_MIX2_SET;
      S_MIX2_SET:  state_nxt = last_r ? S_SP_MOD : S_OUT;
      S_SP_MOD:    if (last_step) state_nxt = S_SP_SET;
      S_SP_SET:    state_nxt = S_OUT;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      dly_len_r   <= DLEN_W'(MAX_DELAY);
      swp_len_r   <= SLEN_W'(SWEEP_DEPTH);
      phase_r     <= PH_W'(16384);
      fbg_r       <= '0;
      wet_r       <= WET_W'(27211);
      dry_r       <= DRY_W'(38326);
      quad_r      <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_q_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + DL_AW'(1);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DELAY_LENGTH:   dly_len_r <= dly_cfg;
          REG_SWEEP_LENGTH:   swp_len_r <= swp_cfg;
          REG_CHANNEL_PHASE:  phase_r   <= ph_cfg;
          REG_FEEDBACK_GAIN:  fbg_r     <= cfg_wdata;
          REG_WET_GAIN:       wet_r     <= cfg_wdata[WET_W-1:0];
          REG_DRY_GAIN:       dry_r     <= cfg_wdata[DRY_W-1:0];
          REG_QUADRATIC_MODE: quad_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_WP_SET && first_r) wp_r <= pos_val;
      if (state_r == S_SP_SET) sp_r <= rem_r[SA_W-1:0];
      if (state_r == S_DEL_SET) last_q_r[ch_r[CH_W-1:0]] <= del_val;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sweep table
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_cmd) tbl_mem[in_table_index[SA_W-1:0]] <= in_table_value;
    if (state_r == S_IDX_MOD && last_step) tbl_q_r <= tbl_mem[rem_nxt[SA_W-1:0]];
  end

  // delay memory, one line per channel
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      dl_mem[clr_cnt_r] <= '0;
    end else if (state_r == S_FB_WR) begin
      dl_mem[{ch_r[CH_W-1:0], pos_r}] <= wr_val;
    end
    if (state_r == S_TAP_RD) dl_q_r <= dl_mem[{ch_r[CH_W-1:0], rem_r[DA_W-1:0]}];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (sample_acc) begin
          ch_r    <= in_channel;
          x_r     <= in_sample_in;
          first_r <= in_first_of_frame;
          last_r  <= in_last_of_frame;
          num_r   <= MOD_W'(wp_r) << (MOD_W - WP_N);
          rem_r   <= '0;
          div_r   <= REM_W'(dly_len_r);
          cnt_r   <= CNT_W'(WP_N);
        end
      end
      S_WP_MOD, S_IDX_MOD, S_TAP_MOD, S_SP_MOD: begin
        rem_r <= rem_nxt;
        num_r <= num_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_WP_SET: begin
        pos_r  <= pos_val;
        mc_r   <= MC_W'({1'b0, ch_sl});
        mb_r   <= phase_r;
        msgn_r <= 1'b0;
        acc_r  <= '0;
        cnt_r  <= CNT_W'(MB_W);
      end
      S_OFS_MUL, S_FB_MUL, S_QA_MUL, S_QT_MUL, S_MIX1_MUL, S_MIX2_MUL: begin
        acc_r <= acc_nxt;
        mb_r  <= mb_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_OFS_SET: begin
        num_r <= idx_num;
        rem_r <= '0;
        div_r <= swp_len_r;
        cnt_r <= CNT_W'(IDX_N);
      end
      S_TBL_RD: begin
        tap_k_r <= '0;
        mc_r    <= MC_W'(last_q_r[ch_r[CH_W-1:0]]);
        mb_r    <= fbg_r;
        msgn_r  <= 1'b1;
        acc_r   <= '0;
        cnt_r   <= CNT_W'(MB_W);
      end
      S_FB_WR: ;
      S_TAP_START: begin
        num_r <= MOD_W'(tap_num) << (MOD_W - TAP_N);
        rem_r <= '0;
        div_r <= REM_W'(dly_len_r);
        cnt_r <= CNT_W'(TAP_N);
      end
      S_TAP_RD: ;
      S_TAP_WAIT: begin
        d_r[tap_k_r] <= dl_q_r;
        tap_k_r      <= tap_k_r + 2'd1;
      end
      S_INTERP: begin
        // linear path folded into the quadratic form: (e1 << 17) * f, rounded at bit 33
        mc_r   <= quad_r ? MC_W'(a2) : (MC_W'(e1) <<< 17);
        mb_r   <= MB_W'(frac);
        msgn_r <= 1'b0;
        acc_r  <= '0;
        cnt_r  <= CNT_W'(MB_W);
      end
      S_QA_SUM: begin
        mc_r  <= qsum;
        acc_r <= '0;
        mb_r  <= MB_W'(frac);
        cnt_r <= CNT_W'(MB_W);
      end
      S_DEL_SET: begin
        del_r  <= del_val;
        mc_r   <= MC_W'(x_r);
        mb_r   <= dry_r;
        msgn_r <= 1'b0;
        acc_r  <= '0;
        cnt_r  <= CNT_W'(MB_W);
      end
      S_MIX1_SET: begin
        p1_r  <= acc_r;
        mc_r  <= MC_W'(del_r);
        mb_r  <= MB_W'(wet_r);
        acc_r <= '0;
        cnt_r <= CNT_W'(MB_W);
      end
      S_MIX2_SET: begin
        y_r   <= mix_val;
        num_r <= MOD_W'(SP_N'(sp_r) + SP_N'(1)) << (MOD_W - SP_N);
        rem_r <= '0;
        div_r <= swp_len_r;
        cnt_r <= CNT_W'(SP_N);
      end
      S_SP_SET: ;
      S_OUT: begin
        if (out_free) begin
          out_sample_r  <= y_r;
          out_channel_r <= ch_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/afl_checker.sv =====
// afl_checker: port-level assertions for audio_flanger_delay_line_core, with its bind
// depends on afl_pkg and on the top level port names
`timescale 1ns / 1ps

module afl_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   in_cmd,
  input logic [afl_pkg::CHAN_W-1:0]             in_channel,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [afl_pkg::SAMPLE_BITS-1:0] out_sample_out,
  input logic [afl_pkg::CHAN_W-1:0]             out_channel
);
  import afl_pkg::*;

  logic [CHAN_W-1:0] ch_seen_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && !in_cmd) ch_seen_r <= in_channel;
  end

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_channel))
    else $error("result changed while stalled");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one sample in flight at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd |=> !in_ready)
    else $error("ready held after sample transfer");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> in_ready)
    else $error("table load stalled input");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_channel == ch_seen_r)
    else $error("result channel mismatch");

endmodule

bind audio_flanger_delay_line_core afl_checker u_afl_checker (.*);

// ===== tb/sv/tb_audio_flanger_delay_line_core.sv =====
// self-checking testbench for audio_flanger_delay_line_core: random frames, table loads
// and register settings checked against an in-bench flanger predictor; needs afl_pkg
`timescale 1ns / 1ps

module tb_audio_flanger_delay_line_core;
  import afl_pkg::*;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;
  localparam int   WATCHDOG   = 100000;
  localparam int   SETTLE     = 260;
  localparam int   LONG_HOLD  = 600;
  localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS-1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef struct {
    logic                          cmd;
    logic [CHAN_W-1:0]             channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
    logic                          last;
    logic [TI_W-1:0]               tidx;
    logic [TV_W-1:0]               tval;
  } flange_item_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CHAN_W-1:0]      channel;
  } flange_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic [CHAN_W-1:0] in_channel = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic in_first_of_frame = 1'b0;
  logic in_last_of_frame = 1'b0;
  logic [TI_W-1:0] in_table_index = '0;
  logic [TV_W-1:0] in_table_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic [CHAN_W-1:0] out_channel;
  logic cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  audio_flanger_delay_line_core uut (.*);

  always #5 clk = ~clk;

  // flanger state as the block should hold it
  longint      line_mem [CHANNELS][MAX_DELAY];
  longint      last_del [CHANNELS];
  int unsigned wr_pos;
  int unsigned sweep_pos;
  int unsigned sweep_mem [SWEEP_DEPTH];
  int unsigned dly_len, swp_len, ch_phase, wet, dry;
  longint      fb_gain;
  bit          quad;

  flange_item_t pending_items[$];
  flange_out_t  expected_mix[$];
  bit           table_loaded [SWEEP_DEPTH];
  int unsigned  gen_sweep_pos;
  int           errors = 0;
  bit           quiet = 1'b0;
  bit           hold_start = 1'b0;

  function automatic longint clip(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic int unsigned tap_index(input int unsigned ch, input int unsigned spos);
    longint unsigned offs;
    offs = (longint'(ch) * swp_len * ch_phase + 32768) >> 16;
    return int'((spos % swp_len + offs) % swp_len);
  endfunction

  function automatic void flange_predict(input flange_item_t it);
    int unsigned ch, L, pos, tv, ip;
    longint x, f, d0, d1, d2, e1, e2, a2, b2, del, y;
    flange_out_t r;
    if (it.cmd == CMD_LOAD) begin
      sweep_mem[it.tidx] = it.tval;
      return;
    end
    ch = it.channel;
    L = dly_len;
    if (it.first) wr_pos = (wr_pos % L + L - 1) % L;
    pos = wr_pos % L;
    tv = sweep_mem[tap_index(ch, sweep_pos)];
    ip = (tv >> 16) & 32'h7FF;
    f = tv & 32'hFFFF;
    x = it.sample;
    line_mem[ch][pos] = clip(x + ((last_del[ch] * fb_gain + 32768) >>> 16));
    d0 = line_mem[ch][(pos + ip) % L];
    d1 = line_mem[ch][(pos + ip + 1) % L];
    if (!quad) begin
      del = d0 + (((d1 - d0) * f + 32768) >>> 16);
    end else begin
      d2 = line_mem[ch][(pos + ip + 2) % L];
      e1 = d1 - d0;
      e2 = d2 - d0;
      a2 = e2 - 2 * e1;
      b2 = 4 * e1 - e2;
      del = d0 + ((a2 * f * f + b2 * f * 65536 + (64'sd1 <<< 32)) >>> 33);
    end
    del = clip(del);
    last_del[ch] = del;
    y = clip((x * longint'(dry) + del * longint'(wet) + 32768) >>> 16);
    if (it.last) sweep_pos = (sweep_pos % swp_len + 1) % swp_len;
    r.sample = y[SAMPLE_BITS-1:0];
    r.channel = ch[CHAN_W-1:0];
    expected_mix.push_back(r);
  endfunction

  // register write; the bench issues it only while the block is idle, the block itself does not enforce that
  task automatic write_reg(input cfg_reg_t r, input int unsigned v);
    logic [CFG_W-1:0] b;
    b = v[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= b;
    case (r)
      REG_DELAY_LENGTH: begin
        dly_len = b[DLEN_W-1:0];
        if (dly_len < 3) dly_len = 3;
        if (dly_len > MAX_DELAY) dly_len = MAX_DELAY;
      end
      REG_SWEEP_LENGTH: begin
        swp_len = b;
        if (swp_len < 1) swp_len = 1;
        if (swp_len > SWEEP_DEPTH) swp_len = SWEEP_DEPTH;
      end
      REG_CHANNEL_PHASE: ch_phase = (b > 65536) ? 65536 : b;
      REG_FEEDBACK_GAIN: fb_gain = longint'($signed(b));
      REG_WET_GAIN:      wet = b[WET_W-1:0];
      REG_DRY_GAIN:      dry = b;
      default:           quad = b[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input int unsigned dl, input int unsigned sl, input int unsigned ph,
                         input int unsigned fb, input int unsigned wg, input int unsigned dg,
                         input int unsigned qm);
    write_reg(REG_DELAY_LENGTH, dl);
    write_reg(REG_SWEEP_LENGTH, sl);
    write_reg(REG_CHANNEL_PHASE, ph);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_WET_GAIN, wg);
    write_reg(REG_DRY_GAIN, dg);
    write_reg(REG_QUADRATIC_MODE, qm);
  endtask

  task automatic push_load(input int unsigned idx, input int unsigned val);
    flange_item_t it;
    it.cmd = CMD_LOAD;
    it.channel = CHAN_W'($urandom);
    it.sample = SAMPLE_BITS'($urandom);
    it.first = 1'($urandom);
    it.last = 1'($urandom);
    it.tidx = idx[TI_W-1:0];
    it.tval = val[TV_W-1:0];
    table_loaded[it.tidx] = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SMAX[SAMPLE_BITS-1:0];
      1:       return SMIN[SAMPLE_BITS-1:0];
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // the table entry this sample will read gets loaded first if it never was
  task automatic push_sample(input int unsigned ch, input logic signed [SAMPLE_BITS-1:0] s,
                             input bit first, input bit last);
    flange_item_t it;
    int unsigned idx;
    idx = tap_index(ch, gen_sweep_pos);
    if (!table_loaded[idx]) push_load(idx, $urandom_range(0, (1 << TV_W) - 1));
    it.cmd = CMD_SAMPLE;
    it.channel = ch[CHAN_W-1:0];
    it.sample = s;
    it.first = first;
    it.last = last;
    it.tidx = TI_W'($urandom);
    it.tval = TV_W'($urandom);
    pending_items.push_back(it);
    if (last) gen_sweep_pos = (gen_sweep_pos % swp_len + 1) % swp_len;
  endtask

  task automatic push_random(input int n);
    int made, nch;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_load($urandom_range(0, SWEEP_DEPTH - 1), $urandom_range(0, (1 << TV_W) - 1));
        made++;
      end else if ($urandom_range(0, 9) == 0) begin
        push_sample($urandom_range(0, CHANNELS - 1), pick_sample(), 1'($urandom),
                    1'($urandom));
        made++;
      end else begin
        nch = $urandom_range(1, CHANNELS);
        for (int c = 0; c < nch; c++)
          push_sample(c, pick_sample(), c == 0, c == nch - 1);
        made += nch;
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_mix.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sender: offers queued items, with occasional bursts of idle cycles between them
  bit in_took = 1'b0;
  int send_gap = 0;
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      flange_predict('{in_cmd, in_channel, in_sample_in, in_first_of_frame,
                       in_last_of_frame, in_table_index, in_table_value});
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      flange_item_t it;
      it = pending_items.pop_front();
      in_valid <= 1'b1;
      in_cmd <= it.cmd;
      in_channel <= it.channel;
      in_sample_in <= it.sample;
      in_first_of_frame <= it.first;
      in_last_of_frame <= it.last;
      in_table_index <= it.tidx;
      in_table_value <= it.tval;
      if (!quiet && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 12);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  int  rdy_left = 0;
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_start && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (rdy_left > 0) begin
      rdy_left <= rdy_left - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      rdy_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
      rdy_left <= $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(0, 11);
    end
  end

  // result check against the oldest expected mix
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_mix.size() == 0) begin
        $error("unexpected transfer: sample_out %0d channel %0d", out_sample_out, out_channel);
        errors++;
      end else begin
        flange_out_t e;
        e = expected_mix.pop_front();
        if (out_sample_out !== e.sample) begin
          $error("sample_out expected %0d actual %0d", $signed(e.sample), out_sample_out);
          errors++;
        end
        if (out_channel !== e.channel) begin
          $error("out_channel expected %0d actual %0d", e.channel, out_channel);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("audio_flanger_delay_line_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      last_del[c] = 0;
      for (int p = 0; p < MAX_DELAY; p++) line_mem[c][p] = 0;
    end
    wr_pos = 0;
    sweep_pos = 0;
    gen_sweep_pos = 0;
    dly_len = 2048;
    swp_len = 65536;
    ch_phase = 16384;
    fb_gain = 0;
    wet = 27211;
    dry = 38326;
    quad = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, both table ends, both flags, every channel
    push_load(0, 0);
    push_load(SWEEP_DEPTH - 1, (1 << TV_W) - 1);
    push_load(1, 32'h0001_8000);
    for (int c = 0; c < CHANNELS; c++)
      push_sample(c, (c % 2) ? SMIN[SAMPLE_BITS-1:0] : SMAX[SAMPLE_BITS-1:0],
                  c == 0, c == CHANNELS - 1);
    push_sample(0, 0, 1, 0);
    push_sample(7, -1, 0, 1);
    push_sample(3, 1, 1, 1);
    push_sample(5, 24'sh2AAAAA, 0, 0);
    push_sample(2, 24'sh555555, 1, 1);
    drain();

    // extremes, then out-of-range values that get clamped, then random settings
    set_all(3, 1, 0, 62259, 32768, 65536, 1);
    gen_sweep_pos = sweep_pos;
    hold_start = 1'b1;
    push_random(170);
    drain();
    set_all(2048, 65536, 65536, 32'h1_0CCD, 0, 32768, 0);
    gen_sweep_pos = sweep_pos;
    push_random(170);
    drain();
    set_all(0, 0, 32'h1_FFFF, 32'h1_0000, 16'hFFFF, 32'h1_FFFF, 1);
    gen_sweep_pos = sweep_pos;
    push_random(170);
    drain();
    set_all(4095, 32'h1_FFFF, 70000, 32'h0_FFFF, 0, 0, 0);
    gen_sweep_pos = sweep_pos;
    push_random(120);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_all($urandom_range(3, 64), $urandom_range(1, 40), $urandom_range(0, 65536),
              $urandom_range(0, 2 * 62259) - 62259, $urandom_range(0, 32768),
              $urandom_range(32768, 65536), $urandom_range(0, 1));
      gen_sweep_pos = sweep_pos;
      if (ph == 3) quiet = 1'b1;
      push_random(140);
      drain();
    end

    if (errors == 0) begin
      $display("audio_flanger_delay_line_core: match");
    end else begin
      $display("audio_flanger_delay_line_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/afl_pkg.sv
design/audio_flanger_delay_line_core.sv
design/afl_checker.sv
tb/sv/tb_audio_flanger_delay_line_core.sv
